>>> hw/rtl/fcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types, constants and a helper function of the flow cutoff meter.
// ----------------------------------------------------------------------------
package fcm_pkg;

    // Field widths
    localparam int KEY_W     = 297;   // src_high, src_low, dst_high, dst_low, ports, family+proto
    localparam int PKT_W     = 32;
    localparam int BYTE_W    = 40;
    localparam int TIME_W    = 64;
    localparam int LEN_W     = 16;
    localparam int ENT_W     = TIME_W + PKT_W + BYTE_W;
    localparam int SET_W_MAX = 17;
    localparam int KEY_BYTES = 38;
    localparam int CFG_W     = 40;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_DROP  = 2'd1;
    localparam logic [1:0] VERDICT_ABORT = 2'd2;

    // Frame classes
    localparam logic [1:0] CLASS_IPV4 = 2'd1;
    localparam logic [1:0] CLASS_IPV6 = 2'd2;

    // Protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Configuration register indexes
    localparam logic REG_CUTOFF_PACKETS = 1'b0;
    localparam logic REG_CUTOFF_BYTES   = 1'b1;

    // Reset values of the cutoffs
    localparam logic [PKT_W-1:0]  CUTOFF_PACKETS_RST = 32'd5024;
    localparam logic [BYTE_W-1:0] CUTOFF_BYTES_RST   = 40'd1048576;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOR  = 32'hFFFFFFFF;

    // One job handed from the front to the back
    typedef struct packed {
        logic                 lookup;
        logic [1:0]           verdict;
        logic [KEY_W-1:0]     key;
        logic [SET_W_MAX-1:0] set;
        logic [LEN_W-1:0]     len;
        logic [TIME_W-1:0]    now;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CRC,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CMP,
        B_UPD
    } t_back_state;

    // Advance the CRC by one byte, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/fcm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_in_if
// Packet summary channel: valid, ready and the parsed packet fields.
// ----------------------------------------------------------------------------
interface fcm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_class;
    logic        l3_complete;
    logic        l4_complete;
    logic [7:0]  protocol;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] frame_length;
    logic [63:0] now_ns;

    modport source (
        output valid, frame_class, l3_complete, l4_complete, protocol,
               src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
               src_port, dst_port, frame_length, now_ns,
        input  ready
    );
    modport sink (
        input  valid, frame_class, l3_complete, l4_complete, protocol,
               src_addr_high, src_addr_low, dst_addr_high, dst_addr_low,
               src_port, dst_port, frame_length, now_ns,
        output ready
    );
endinterface

>>> hw/rtl/fcm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_out_if
// Verdict channel: valid, ready and the per-packet result fields.
// ----------------------------------------------------------------------------
interface fcm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic        tracked;
    logic        new_flow;
    logic        table_full;
    logic [31:0] flow_packets;
    logic [39:0] flow_bytes;

    modport source (
        output valid, verdict, tracked, new_flow, table_full, flow_packets, flow_bytes,
        input  ready
    );
    modport sink (
        input  valid, verdict, tracked, new_flow, table_full, flow_packets, flow_bytes,
        output ready
    );
endinterface

>>> hw/rtl/flow_cutoff_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_cutoff_meter_core
// Five-tuple flow table with per-flow packet and byte cutoffs.
// ----------------------------------------------------------------------------
// Each packet summary beat gets one verdict beat, in order. Summaries that
// need a table lookup pass through the front's accept step, CRC-32 at one
// key byte per cycle over the 38 key bytes, a remainder by TABLE_SETS
// through reciprocal multiplication, and a hand-off step; this hash unit
// sets the sustained rate. Other summaries go straight from accept to
// hand-off. The table side reads, compares and updates for a lookup and
// only updates for a bypassed summary, and runs in parallel with the next
// hash through a two-entry queue. After reset the table's valid bits are
// swept clear, one set per cycle; no summary is accepted during the sweep,
// configuration writes are.
module flow_cutoff_meter_core import fcm_pkg::*; #(
    parameter int TABLE_SETS = 1024,
    parameter int TABLE_WAYS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fcm_in_if.sink           i_in,
    fcm_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [PKT_W-1:0]  r_cutoff_packets;
    logic [BYTE_W-1:0] r_cutoff_bytes;
    logic              clear_busy;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    t_job              push_job, pop_job;

    // Cutoff registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_packets <= CUTOFF_PACKETS_RST;
            r_cutoff_bytes   <= CUTOFF_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CUTOFF_PACKETS: r_cutoff_packets <= i_cfg_data[PKT_W-1:0];
                REG_CUTOFF_BYTES:   r_cutoff_bytes   <= i_cfg_data[BYTE_W-1:0];
                default:            r_cutoff_bytes   <= r_cutoff_bytes;
            endcase
        end
    end

    fcm_front #(.TABLE_SETS(TABLE_SETS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_enable(!clear_busy), .i_in(i_in),
        .o_push_valid(push_valid), .o_job(push_job), .i_push_ready(push_ready)
    );

    fcm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(push_valid), .i_push_job(push_job), .o_push_ready(push_ready),
        .o_pop_valid(pop_valid), .o_pop_job(pop_job), .i_pop_ready(pop_ready)
    );

    fcm_back #(.TABLE_SETS(TABLE_SETS), .TABLE_WAYS(TABLE_WAYS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pop_valid(pop_valid), .i_pop_job(pop_job), .o_pop_ready(pop_ready),
        .i_cutoff_packets(r_cutoff_packets), .i_cutoff_bytes(r_cutoff_bytes),
        .o_clear_busy(clear_busy), .o_out(o_out)
    );

endmodule

>>> hw/rtl/fcm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/fcm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_front
// Accepts packet summaries, classifies them, builds the flow key and works
// out the set index (CRC-32 a byte per cycle, then a remainder by reciprocal
// multiplication: quotient estimate, its multiple, then one correction).
// ----------------------------------------------------------------------------
module fcm_front import fcm_pkg::*; #(
    parameter int TABLE_SETS = 1024
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_enable,
    fcm_in_if.sink i_in,
    output logic   o_push_valid,
    output t_job   o_job,
    input  logic   i_push_ready
);

    localparam int SW = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
    localparam logic [5:0] LAST_BYTE = 6'(KEY_BYTES - 1);
    // Reciprocal of the set count: the quotient estimate is at most one low.
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TABLE_SETS);

    t_front_state r_state, n_state;
    logic [KEY_W-1:0]  r_key;
    logic              r_lookup;
    logic [1:0]        r_verdict;
    logic [LEN_W-1:0]  r_len;
    logic [TIME_W-1:0] r_now;
    logic [5:0]        r_cnt;
    logic [31:0]       r_crc;
    logic [SW-1:0]     r_rem;
    logic [4:0]        r_bit;
    logic [64:0]       r_prod;
    logic [33:0]       r_qn;

    logic              take;
    logic              l4p;
    logic              cls_lookup;
    logic [1:0]        cls_verdict;
    logic [KEY_W-1:0]  in_key;
    logic [31:0]       in_ports;
    logic [KEY_W+6:0]  stream;
    logic [7:0]        crc_in;
    logic [31:0]       crc_next;
    logic [64:0]       mod_prod;
    logic [50:0]       mod_qn;
    logic [33:0]       mod_diff;

    assign take = i_in.valid && i_in.ready;
    assign l4p  = (i_in.protocol == PROTO_TCP) || (i_in.protocol == PROTO_UDP);

    // Classification of the incoming beat
    always_comb begin
        cls_lookup  = 1'b0;
        cls_verdict = VERDICT_PASS;
        if (i_in.frame_class != CLASS_IPV4 && i_in.frame_class != CLASS_IPV6) begin
            cls_lookup = 1'b0;
        end else if (!i_in.l3_complete) begin
            cls_verdict = VERDICT_ABORT;
        end else if (i_in.frame_class == CLASS_IPV6 && !l4p) begin
            cls_lookup = 1'b0;
        end else if (l4p && !i_in.l4_complete) begin
            cls_lookup = 1'b0;
        end else begin
            cls_lookup = 1'b1;
        end
    end

    // Key in hashing order: the lowest byte is hashed first.
    always_comb begin
        in_ports = l4p ? {i_in.src_port, i_in.dst_port} : 32'd0;
        if (i_in.frame_class == CLASS_IPV4) begin
            in_key = {1'b0, i_in.protocol, in_ports,
                      32'd0, i_in.dst_addr_low[31:0], 64'd0,
                      32'd0, i_in.src_addr_low[31:0], 64'd0};
        end else begin
            in_key = {1'b1, i_in.protocol, in_ports,
                      i_in.dst_addr_low, i_in.dst_addr_high,
                      i_in.src_addr_low, i_in.src_addr_high};
        end
    end

    assign stream    = {7'd0, r_key};
    assign crc_in    = stream[{r_cnt, 3'b000} +: 8];
    assign crc_next  = crc_byte(r_crc, crc_in);

    // Remainder steps: quotient estimate, its multiple, then one correction.
    assign mod_prod = 65'(r_crc) * 65'(RECIP);
    assign mod_qn   = 51'(r_prod[64:32]) * 51'(TABLE_SETS);
    assign mod_diff = {2'b00, r_crc} - r_qn;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (take) begin
                    n_state = cls_lookup ? F_CRC : F_PUSH;
                end
            end
            F_CRC: begin
                if (r_cnt == LAST_BYTE) begin
                    n_state = F_MOD;
                end
            end
            F_MOD: begin
                if (r_bit == 5'd0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_in.ready   = (r_state == F_IDLE) && i_enable;
        o_push_valid = (r_state == F_PUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the hash and remainder
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (take) begin
                    r_key     <= in_key;
                    r_lookup  <= cls_lookup;
                    r_verdict <= cls_verdict;
                    r_len     <= i_in.frame_length;
                    r_now     <= i_in.now_ns;
                    r_cnt     <= 6'd0;
                    r_crc     <= CRC_INIT;
                    r_rem     <= '0;
                end
            end
            F_CRC: begin
                r_cnt <= r_cnt + 6'd1;
                r_bit <= 5'd2;
                if (r_cnt == LAST_BYTE) begin
                    r_crc <= crc_next ^ CRC_XOR;
                end else begin
                    r_crc <= crc_next;
                end
            end
            F_MOD: begin
                r_bit <= r_bit - 5'd1;
                if (r_bit == 5'd2) begin
                    r_prod <= mod_prod;
                end else if (r_bit == 5'd1) begin
                    r_qn <= mod_qn[33:0];
                end else if (mod_diff >= 34'(TABLE_SETS)) begin
                    r_rem <= SW'(mod_diff - 34'(TABLE_SETS));
                end else begin
                    r_rem <= mod_diff[SW-1:0];
                end
            end
            F_PUSH: begin
                r_cnt <= r_cnt;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_job.lookup  = r_lookup;
    assign o_job.verdict = r_verdict;
    assign o_job.key     = r_key;
    assign o_job.set     = SET_W_MAX'(r_rem);
    assign o_job.len     = r_len;
    assign o_job.now     = r_now;

endmodule

>>> hw/rtl/fcm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_queue
// Two-entry job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module fcm_queue import fcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop_ready
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_job    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_job;
        end
    end

endmodule

>>> hw/rtl/fcm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_back
// Flow table: clears the valid bits after reset, then for a lookup reads a set,
// compares the ways and updates or inserts the flow; every job registers a verdict beat.
// ----------------------------------------------------------------------------
module fcm_back import fcm_pkg::*; #(
    parameter int TABLE_SETS = 1024,
    parameter int TABLE_WAYS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  t_job              i_pop_job,
    output logic              o_pop_ready,
    input  logic [PKT_W-1:0]  i_cutoff_packets,
    input  logic [BYTE_W-1:0] i_cutoff_bytes,
    output logic              o_clear_busy,
    fcm_out_if.source         o_out
);

    localparam int SW = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
    localparam int WW = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;

    t_back_state r_state, n_state;
    t_job              r_job;
    logic [SW-1:0]     r_clr;
    logic              r_hit;
    logic              r_free;
    logic [WW-1:0]     r_way;
    logic [PKT_W-1:0]  r_old_pk;
    logic [BYTE_W-1:0] r_old_by;

    logic                        r_out_valid;
    logic [1:0]                  r_out_verdict;
    logic                        r_out_tracked;
    logic                        r_out_new;
    logic                        r_out_full;
    logic [PKT_W-1:0]            r_out_pk;
    logic [BYTE_W-1:0]           r_out_by;

    logic [TABLE_WAYS-1:0]       valid_row, valid_wdata;
    logic [TABLE_WAYS*KEY_W-1:0] key_row, key_wdata;
    logic [TABLE_WAYS*ENT_W-1:0] ent_row, ent_wdata;
    logic                        valid_we, key_we, ent_we;
    logic [SW-1:0]               raddr, waddr;

    logic              c_hit, c_free;
    logic [WW-1:0]     c_hit_way, c_free_way, c_way;
    logic [ENT_W-1:0]  c_ent;
    logic [BYTE_W:0]   by_sum;
    logic [PKT_W-1:0]  new_pk;
    logic [BYTE_W-1:0] new_by;
    logic              slot_free;
    logic              fire;

    logic [1:0]        n_verdict;
    logic              n_tracked, n_new, n_full;
    logic [PKT_W-1:0]  n_pk;
    logic [BYTE_W-1:0] n_by;

    // Table storage: valid bits, keys, and time/counts per way of a set
    fcm_ram #(.WIDTH(TABLE_WAYS), .DEPTH(TABLE_SETS)) u_valid_ram (
        .i_clk(i_clk), .i_we(valid_we), .i_waddr(waddr), .i_wdata(valid_wdata),
        .i_raddr(raddr), .o_rdata(valid_row)
    );
    fcm_ram #(.WIDTH(TABLE_WAYS * KEY_W), .DEPTH(TABLE_SETS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(waddr), .i_wdata(key_wdata),
        .i_raddr(raddr), .o_rdata(key_row)
    );
    fcm_ram #(.WIDTH(TABLE_WAYS * ENT_W), .DEPTH(TABLE_SETS)) u_ent_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(waddr), .i_wdata(ent_wdata),
        .i_raddr(raddr), .o_rdata(ent_row)
    );

    assign raddr     = r_job.set[SW-1:0];
    assign waddr     = (r_state == B_CLEAR) ? r_clr : raddr;
    assign slot_free = !r_out_valid || o_out.ready;
    assign fire      = (r_state == B_UPD) && slot_free;

    // Way compare: first matching valid way, first free way
    always_comb begin
        c_hit      = 1'b0;
        c_free     = 1'b0;
        c_hit_way  = '0;
        c_free_way = '0;
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (valid_row[w]) begin
                if (!c_hit && key_row[w*KEY_W +: KEY_W] == r_job.key) begin
                    c_hit     = 1'b1;
                    c_hit_way = WW'(w);
                end
            end else if (!c_free) begin
                c_free     = 1'b1;
                c_free_way = WW'(w);
            end
        end
        c_way = c_hit ? c_hit_way : c_free_way;
        c_ent = ent_row[c_way*ENT_W +: ENT_W];
    end

    // Saturating count update
    assign by_sum = {1'b0, r_old_by} + (BYTE_W+1)'(r_job.len);
    assign new_by = by_sum[BYTE_W] ? {BYTE_W{1'b1}} : by_sum[BYTE_W-1:0];
    assign new_pk = (&r_old_pk) ? r_old_pk : r_old_pk + PKT_W'(1);

    // Result of the job in hand
    always_comb begin
        n_verdict = r_job.verdict;
        n_tracked = 1'b0;
        n_new     = 1'b0;
        n_full    = 1'b0;
        n_pk      = '0;
        n_by      = '0;
        if (r_job.lookup) begin
            n_verdict = VERDICT_PASS;
            if (r_hit) begin
                n_tracked = 1'b1;
                n_pk      = new_pk;
                n_by      = new_by;
                if (new_pk > i_cutoff_packets || new_by > i_cutoff_bytes) begin
                    n_verdict = VERDICT_DROP;
                end
            end else if (r_free) begin
                n_tracked = 1'b1;
                n_new     = 1'b1;
                n_pk      = PKT_W'(1);
                n_by      = BYTE_W'(r_job.len);
            end else begin
                n_full = 1'b1;
            end
        end
    end

    // Rows written back: the chosen way replaced, the others kept; during the clear the valid row is zero
    always_comb begin
        valid_wdata = valid_row;
        key_wdata   = key_row;
        ent_wdata   = ent_row;
        valid_wdata[r_way] = 1'b1;
        key_wdata[r_way*KEY_W +: KEY_W] = r_job.key;
        ent_wdata[r_way*ENT_W +: ENT_W] = {r_job.now, n_pk, n_by};
        if (r_state == B_CLEAR) begin
            valid_wdata = '0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr == SW'(TABLE_SETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_pop_valid) begin
                    n_state = i_pop_job.lookup ? B_READ : B_UPD;
                end
            end
            B_READ:  n_state = B_CMP;
            B_CMP:   n_state = B_UPD;
            B_UPD: begin
                if (slot_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop_ready  = (r_state == B_IDLE);
        o_clear_busy = (r_state == B_CLEAR);
        valid_we     = (r_state == B_CLEAR) || (fire && r_job.lookup && !r_hit && r_free);
        key_we       = fire && r_job.lookup && !r_hit && r_free;
        ent_we       = fire && r_job.lookup && (r_hit || r_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + SW'(1);
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Job, lookup result and output beat
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_pop_valid) begin
            r_job <= i_pop_job;
        end
        if (r_state == B_CMP) begin
            r_hit    <= c_hit;
            r_free   <= c_free;
            r_way    <= c_way;
            r_old_pk <= c_ent[BYTE_W +: PKT_W];
            r_old_by <= c_ent[BYTE_W-1:0];
        end
        if (fire) begin
            r_out_verdict <= n_verdict;
            r_out_tracked <= n_tracked;
            r_out_new     <= n_new;
            r_out_full    <= n_full;
            r_out_pk      <= n_pk;
            r_out_by      <= n_by;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.verdict      = r_out_verdict;
    assign o_out.tracked      = r_out_tracked;
    assign o_out.new_flow     = r_out_new;
    assign o_out.table_full   = r_out_full;
    assign o_out.flow_packets = r_out_pk;
    assign o_out.flow_bytes   = r_out_by;

endmodule

>>> hw/rtl/fcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_checker
// Port-level checks on the input ready and the verdict beats, bound to the top level.
// ----------------------------------------------------------------------------
module fcm_checker import fcm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic [1:0]  i_verdict,
    input logic        i_tracked,
    input logic        i_new_flow,
    input logic        i_table_full,
    input logic [31:0] i_flow_packets,
    input logic [39:0] i_flow_bytes
);

    // The table sweep follows reset, so no beat is taken straight after it.
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("summary accepted during table clear");

    // An untracked beat carries no counts.
    a_untracked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_tracked) |-> (i_flow_packets == 32'd0 && i_flow_bytes == 40'd0))
        else $error("counts on untracked verdict");

    // A new flow is tracked, passed and has a count of one.
    a_new_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_new_flow) |->
            (i_tracked && i_flow_packets == 32'd1 && i_verdict == VERDICT_PASS))
        else $error("bad new flow verdict");

    // A full set means nothing was inserted.
    a_table_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_table_full) |->
            (!i_tracked && !i_new_flow && i_verdict == VERDICT_PASS))
        else $error("bad table full verdict");

    // Aborted and dropped beats are consistent with tracking.
    a_abort_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_verdict == VERDICT_ABORT || i_verdict == VERDICT_DROP)) |->
            (i_tracked == (i_verdict == VERDICT_DROP)))
        else $error("tracking inconsistent with verdict");

endmodule

bind flow_cutoff_meter_core fcm_checker u_fcm_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_verdict(o_out.verdict),
    .i_tracked(o_out.tracked),
    .i_new_flow(o_out.new_flow),
    .i_table_full(o_out.table_full),
    .i_flow_packets(o_out.flow_packets),
    .i_flow_bytes(o_out.flow_bytes)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow cutoff meter: directed packet summaries
// followed by random flows, each verdict checked against a flow table model.
// ----------------------------------------------------------------------------
module tb_top;
    import fcm_pkg::*;

    localparam int SETS = 1024;
    localparam int WAYS = 4;
    localparam int NUM_RANDOM = 1000;
    localparam logic [39:0] BYTES_MAX = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  frame_class;
        logic        l3_complete;
        logic        l4_complete;
        logic [7:0]  protocol;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] frame_length;
        logic [63:0] now_ns;
    } t_summary;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        tracked;
        logic        new_flow;
        logic        table_full;
        logic [31:0] flow_packets;
        logic [39:0] flow_bytes;
    } t_verdict;

    // Directed row: summary, optional typed-in verdict
    typedef struct {
        t_summary pkt;
        bit       has_exp;
        t_verdict exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    fcm_in_if  in_ch();
    fcm_out_if out_ch();

    flow_cutoff_meter_core #(.TABLE_SETS(SETS), .TABLE_WAYS(WAYS)) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Flow table model
    bit          mdl_valid [SETS*WAYS];
    logic [296:0] mdl_key  [SETS*WAYS];
    logic [31:0] mdl_pkts  [SETS*WAYS];
    logic [39:0] mdl_bytes [SETS*WAYS];
    logic [31:0] lim_packets;
    logic [39:0] lim_bytes;

    t_verdict pending_verdicts[$];
    int  n_errors;
    bit  no_idle_out;
    bit  hold_out;

    // Pool of flows reused by the random part so that flows hit and hit often
    t_summary flow_pool[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [31:0] crc_bytes(input logic [31:0] crc, input logic [63:0] w,
                                              input int nbytes);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < nbytes; i++) begin
            c = c ^ {24'd0, w[8*i +: 8]};
            for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    // Work out the verdict of one summary and update the flow table.
    function automatic t_verdict meter_packet(input t_summary p);
        t_verdict v;
        bit l4p;
        logic [63:0] sh, sl, dh, dl;
        logic [31:0] ports, crc;
        logic [15:0] fp;
        logic [296:0] key;
        int set_idx, hit, freeway, e;
        logic [40:0] sum;
        v = '0;
        hit = -1;
        freeway = -1;
        l4p = (p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP);
        if (p.frame_class != CLASS_IPV4 && p.frame_class != CLASS_IPV6) return v;
        if (!p.l3_complete) begin
            v.verdict = VERDICT_ABORT;
            return v;
        end
        if (p.frame_class == CLASS_IPV6 && !l4p) return v;
        if (l4p && !p.l4_complete) return v;
        ports = l4p ? {p.src_port, p.dst_port} : 32'd0;
        if (p.frame_class == CLASS_IPV4) begin
            sh = '0;
            dh = '0;
            sl = {32'd0, p.src_addr_low[31:0]};
            dl = {32'd0, p.dst_addr_low[31:0]};
            fp = {8'd0, p.protocol};
        end else begin
            sh = p.src_addr_high;
            sl = p.src_addr_low;
            dh = p.dst_addr_high;
            dl = p.dst_addr_low;
            fp = {8'd1, p.protocol};
        end
        key = {sh, sl, dh, dl, ports, fp[8:0]};
        crc = 32'hFFFFFFFF;
        crc = crc_bytes(crc, sh, 8);
        crc = crc_bytes(crc, sl, 8);
        crc = crc_bytes(crc, dh, 8);
        crc = crc_bytes(crc, dl, 8);
        crc = crc_bytes(crc, {32'd0, ports}, 4);
        crc = crc_bytes(crc, {48'd0, fp}, 2);
        crc = crc ^ 32'hFFFFFFFF;
        set_idx = crc % SETS;
        for (int w = 0; w < WAYS; w++) begin
            e = set_idx * WAYS + w;
            if (mdl_valid[e]) begin
                if (hit < 0 && mdl_key[e] == key) hit = w;
            end else if (freeway < 0) begin
                freeway = w;
            end
        end
        if (hit >= 0) begin
            e = set_idx * WAYS + hit;
            if (mdl_pkts[e] != 32'hFFFF_FFFF) mdl_pkts[e]++;
            sum = {1'b0, mdl_bytes[e]} + p.frame_length;
            mdl_bytes[e] = sum[40] ? BYTES_MAX : sum[39:0];
            v.tracked = 1'b1;
            v.flow_packets = mdl_pkts[e];
            v.flow_bytes = mdl_bytes[e];
            if (mdl_pkts[e] > lim_packets || mdl_bytes[e] > lim_bytes)
                v.verdict = VERDICT_DROP;
            return v;
        end
        if (freeway < 0) begin
            v.table_full = 1'b1;
            return v;
        end
        e = set_idx * WAYS + freeway;
        mdl_valid[e] = 1'b1;
        mdl_key[e] = key;
        mdl_pkts[e] = 32'd1;
        mdl_bytes[e] = {24'd0, p.frame_length};
        v.tracked = 1'b1;
        v.new_flow = 1'b1;
        v.flow_packets = 32'd1;
        v.flow_bytes = {24'd0, p.frame_length};
        return v;
    endfunction

    function automatic int set_of(input t_summary p);
        logic [63:0] sh, sl, dh, dl;
        logic [31:0] ports, crc;
        logic [15:0] fp;
        bit l4p;
        l4p = (p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP);
        ports = l4p ? {p.src_port, p.dst_port} : 32'd0;
        if (p.frame_class == CLASS_IPV4) begin
            sh = '0; dh = '0;
            sl = {32'd0, p.src_addr_low[31:0]};
            dl = {32'd0, p.dst_addr_low[31:0]};
            fp = {8'd0, p.protocol};
        end else begin
            sh = p.src_addr_high; sl = p.src_addr_low;
            dh = p.dst_addr_high; dl = p.dst_addr_low;
            fp = {8'd1, p.protocol};
        end
        crc = 32'hFFFFFFFF;
        crc = crc_bytes(crc, sh, 8);
        crc = crc_bytes(crc, sl, 8);
        crc = crc_bytes(crc, dh, 8);
        crc = crc_bytes(crc, dl, 8);
        crc = crc_bytes(crc, {32'd0, ports}, 4);
        crc = crc_bytes(crc, {48'd0, fp}, 2);
        return (crc ^ 32'hFFFFFFFF) % SETS;
    endfunction

    // True when two valid tracked summaries fall in the same table set.
    function automatic bit same_set(input t_summary a, input t_summary b);
        return set_of(a) == set_of(b);
    endfunction

    // Random 64-bit word.
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_summary random_summary();
        t_summary p;
        int pick;
        p.frame_class   = 2'($urandom_range(0, 3));
        p.l3_complete   = ($urandom_range(0, 15) != 0);
        p.l4_complete   = ($urandom_range(0, 15) != 0);
        pick = $urandom_range(0, 9);
        p.protocol      = pick < 4 ? PROTO_TCP : pick < 8 ? PROTO_UDP : 8'($urandom());
        p.src_addr_high = rand64();
        p.src_addr_low  = rand64();
        p.dst_addr_high = rand64();
        p.dst_addr_low  = rand64();
        p.src_port      = 16'($urandom());
        p.dst_port      = 16'($urandom());
        p.frame_length  = 16'($urandom());
        p.now_ns        = rand64();
        return p;
    endfunction

    // Offer one summary beat and wait through clock edges until ready is seen high after one. Valid stays high so
    // that a following beat can go straight after; wait_drained drops it.
    task automatic send_summary(input t_summary p, input bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.frame_class   <= p.frame_class;
        in_ch.l3_complete   <= p.l3_complete;
        in_ch.l4_complete   <= p.l4_complete;
        in_ch.protocol      <= p.protocol;
        in_ch.src_addr_high <= p.src_addr_high;
        in_ch.src_addr_low  <= p.src_addr_low;
        in_ch.dst_addr_high <= p.dst_addr_high;
        in_ch.dst_addr_low  <= p.dst_addr_low;
        in_ch.src_port      <= p.src_port;
        in_ch.dst_port      <= p.dst_port;
        in_ch.frame_length  <= p.frame_length;
        in_ch.now_ns        <= p.now_ns;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_verdicts.push_back(meter_packet(p));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cutoff(input logic idx, input logic [39:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_CUTOFF_PACKETS) lim_packets = value[31:0];
        else lim_bytes = value;
    endtask

    // Verdict side: random stalls, checked against the oldest expectation
    initial begin
        t_verdict got, want;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            out_ch.ready <= !hold_out && (no_idle_out || $urandom_range(0, 99) >= 25);
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.verdict, out_ch.tracked, out_ch.new_flow, out_ch.table_full,
                       out_ch.flow_packets, out_ch.flow_bytes};
                if (pending_verdicts.size() == 0) begin
                    $error("verdict beat with nothing expected");
                    n_errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                        n_errors++;
                    end
                    if (got.tracked !== want.tracked) begin
                        $error("tracked: expected %0d, got %0d", want.tracked, got.tracked);
                        n_errors++;
                    end
                    if (got.new_flow !== want.new_flow) begin
                        $error("new_flow: expected %0d, got %0d", want.new_flow, got.new_flow);
                        n_errors++;
                    end
                    if (got.table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, got.table_full);
                        n_errors++;
                    end
                    if (got.flow_packets !== want.flow_packets) begin
                        $error("flow_packets: expected %0d, got %0d",
                               want.flow_packets, got.flow_packets);
                        n_errors++;
                    end
                    if (got.flow_bytes !== want.flow_bytes) begin
                        $error("flow_bytes: expected %0d, got %0d",
                               want.flow_bytes, got.flow_bytes);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Main stimulus
    initial begin
        t_row rows[$];
        t_row r;
        t_summary p, base;
        int k;
        n_errors = 0;
        no_idle_out = 1'b0;
        hold_out = 1'b0;
        lim_packets = CUTOFF_PACKETS_RST;
        lim_bytes = CUTOFF_BYTES_RST;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_CUTOFF_PACKETS;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.frame_class = '0;
        in_ch.l3_complete = 1'b0;
        in_ch.l4_complete = 1'b0;
        in_ch.protocol = '0;
        in_ch.src_addr_high = '0;
        in_ch.src_addr_low = '0;
        in_ch.dst_addr_high = '0;
        in_ch.dst_addr_low = '0;
        in_ch.src_port = '0;
        in_ch.dst_port = '0;
        in_ch.frame_length = '0;
        in_ch.now_ns = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: each special case, extremes, then a repeated flow
        base = '0;
        base.frame_class = CLASS_IPV4;
        base.l3_complete = 1'b1;
        base.l4_complete = 1'b1;
        base.protocol = PROTO_TCP;
        base.src_addr_low = 64'h0000_0000_0A00_0001;
        base.dst_addr_low = 64'h0000_0000_0A00_0002;
        base.src_port = 16'd1234;
        base.dst_port = 16'd80;
        base.frame_length = 16'd64;
        // Non-IP and unused class: pass, untracked
        r.pkt = base; r.pkt.frame_class = 2'd0; r.has_exp = 1; r.exp = '0; rows.push_back(r);
        r.pkt = base; r.pkt.frame_class = 2'd3; rows.push_back(r);
        // Truncated IP header, both families: abort
        r.pkt = base; r.pkt.l3_complete = 0; r.exp = '0; r.exp.verdict = VERDICT_ABORT;
        rows.push_back(r);
        r.pkt.frame_class = CLASS_IPV6; rows.push_back(r);
        // IPv6 non-TCP/UDP and truncated TCP header: pass, untracked
        r.pkt = base; r.pkt.frame_class = CLASS_IPV6; r.pkt.protocol = 8'd58; r.exp = '0;
        rows.push_back(r);
        r.pkt = base; r.pkt.l4_complete = 0; rows.push_back(r);
        // New IPv4 TCP flow, then a hit on it (high address bits ignored)
        r.pkt = base; r.exp = '0; r.exp.tracked = 1; r.exp.new_flow = 1;
        r.exp.flow_packets = 1; r.exp.flow_bytes = 64; rows.push_back(r);
        r.pkt.src_addr_high = '1; r.pkt.src_addr_low[63:32] = '1; r.exp.new_flow = 0;
        r.exp.flow_packets = 2; r.exp.flow_bytes = 128; rows.push_back(r);
        // New flow at the largest frame length, ports and time stamp is passed
        r.pkt = base; r.pkt.src_port = 16'hFFFF; r.pkt.dst_port = 16'hFFFF;
        r.pkt.frame_length = 16'hFFFF; r.pkt.now_ns = '1; r.has_exp = 0; rows.push_back(r);
        for (int i = 0; i < 17; i++) rows.push_back(r);    // goes past the byte cutoff
        // IPv4 non-TCP/UDP: ports ignored
        r.pkt = base; r.pkt.protocol = 8'd1; r.pkt.src_port = 16'h5555; rows.push_back(r);
        r.pkt.src_port = 16'hAAAA; rows.push_back(r);
        // IPv6 UDP at the address extremes
        r.pkt = base; r.pkt.frame_class = CLASS_IPV6; r.pkt.protocol = PROTO_UDP;
        r.pkt.src_addr_high = '1; r.pkt.src_addr_low = '1; r.pkt.dst_addr_high = '1;
        r.pkt.dst_addr_low = '1; rows.push_back(r);
        rows.push_back(r);

        foreach (rows[i]) begin
            send_summary(rows[i].pkt, 1'b1);
            if (rows[i].has_exp && pending_verdicts[$] !== rows[i].exp) begin
                $error("directed row %0d: table entry disagrees with the flow model", i);
                n_errors++;
            end
        end
        wait_drained();

        // Tight cutoffs at the low extreme: further packets of a flow dropped
        write_cutoff(REG_CUTOFF_PACKETS, 40'd0);
        write_cutoff(REG_CUTOFF_BYTES, 40'd0);
        p = base;
        send_summary(p, 1'b0);
        p.frame_length = 16'd0;
        send_summary(p, 1'b0);
        wait_drained();
        write_cutoff(REG_CUTOFF_PACKETS, 40'hFFFF_FFFF);
        write_cutoff(REG_CUTOFF_BYTES, BYTES_MAX);

        // Fill one set: five IPv6 flows of that set, found by searching the model
        begin
            int found;
            t_summary probe;
            found = 0;
            k = 0;
            while (found < WAYS + 1) begin
                probe = base;
                probe.frame_class = CLASS_IPV6;
                probe.protocol = PROTO_UDP;
                probe.src_addr_low = 64'(k);
                k++;
                if (same_set(probe, base)) begin
                    send_summary(probe, 1'b0);
                    found++;
                end
            end
        end
        wait_drained();

        // Random part with a receiver hold-off and a stretch without idling
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 200) begin
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (2000) @(posedge i_clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            no_idle_out = (n >= 500 && n < 650);
            if (n == 700) wait_drained();
            if (n == 400 || n == 800) begin
                wait_drained();
                write_cutoff(REG_CUTOFF_PACKETS, 40'($urandom_range(1, 8)));
                write_cutoff(REG_CUTOFF_BYTES, 40'($urandom_range(1000, 400000)));
            end
            if (flow_pool.size() != 0 && $urandom_range(0, 99) < 70) begin
                p = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                p.frame_length = 16'($urandom());
                p.now_ns = rand64();
            end else begin
                p = random_summary();
                if (flow_pool.size() < 64) flow_pool.push_back(p);
            end
            send_summary(p, !(n >= 500 && n < 650));
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
